FILE: src/spiee_pkg.sv
// Shared types and constants for the SPI serial EEPROM byte access master.
// No dependencies; every other file in src imports this package.
`timescale 1ns / 1ps
`default_nettype none

package spiee_pkg;

	// Item kinds on the input channel
	localparam logic [1:0] KIND_READ  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_TICK  = 2'd2;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_WREN     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WRDI     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RDSR     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_READ_LO  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_READ_HI  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WRITE_LO = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_WRITE_HI = 3'd6;

	// Opcode reset values
	localparam logic [7:0] RST_WREN     = 8'h06;
	localparam logic [7:0] RST_WRDI     = 8'h04;
	localparam logic [7:0] RST_RDSR     = 8'h05;
	localparam logic [7:0] RST_READ_LO  = 8'h03;
	localparam logic [7:0] RST_READ_HI  = 8'h0b;
	localparam logic [7:0] RST_WRITE_LO = 8'h02;
	localparam logic [7:0] RST_WRITE_HI = 8'h0a;

	// Ticks spent between the write frame and the first status poll
	localparam logic [2:0] SETTLE_TICKS = 3'd5;

	// Byte slot that marks the chip select release tick at the end of a frame
	localparam logic [1:0] BYTE_GAP = 2'd3;

	// Status bit 0: write in progress
	localparam int STATUS_WIP_BIT = 0;

	// Address bit that picks the high/low opcode variant
	localparam int ADDR_HI_BIT = 8;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_READ   = 3'd1,
		PH_WREN   = 3'd2,
		PH_WRITE  = 3'd3,
		PH_SETTLE = 3'd4,
		PH_POLL   = 3'd5,
		PH_WRDI   = 3'd6
	} phase_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [8:0] address;
		logic [7:0] write_data;
		logic       miso;
	} in_item_t;

	typedef struct packed {
		logic       chip_select_n;
		logic       serial_clock;
		logic       mosi;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
		logic       rejected;
	} out_item_t;

	typedef struct packed {
		logic [7:0] wren;
		logic [7:0] wrdi;
		logic [7:0] rdsr;
		logic [7:0] read_lo;
		logic [7:0] read_hi;
		logic [7:0] write_lo;
		logic [7:0] write_hi;
	} opcodes_t;

	// Number of bytes in the frame of a phase
	function automatic logic [1:0] frame_bytes(phase_t ph);
		logic [1:0] n;
		unique case (ph)
			PH_READ, PH_WRITE: n = 2'd3;
			PH_POLL:           n = 2'd2;
			default:           n = 2'd1;
		endcase
		return n;
	endfunction

endpackage

`default_nettype wire

FILE: src/spiee_cfg.sv
// Opcode register file for the SPI EEPROM master: one write port, no read-back.
// Depends on spiee_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spiee_cfg
	import spiee_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_write,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]           cfg_data,
	output opcodes_t                  opcodes
);

	opcodes_t opc_q;

	// Register writes; an index past the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opc_q <= '{wren: RST_WREN, wrdi: RST_WRDI, rdsr: RST_RDSR,
				read_lo: RST_READ_LO, read_hi: RST_READ_HI,
				write_lo: RST_WRITE_LO, write_hi: RST_WRITE_HI};
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_WREN:     opc_q.wren     <= cfg_data;
				REG_WRDI:     opc_q.wrdi     <= cfg_data;
				REG_RDSR:     opc_q.rdsr     <= cfg_data;
				REG_READ_LO:  opc_q.read_lo  <= cfg_data;
				REG_READ_HI:  opc_q.read_hi  <= cfg_data;
				REG_WRITE_LO: opc_q.write_lo <= cfg_data;
				REG_WRITE_HI: opc_q.write_hi <= cfg_data;
				default:      ;
			endcase
		end
	end

	assign opcodes = opc_q;

endmodule

`default_nettype wire

FILE: src/spiee_seq.sv
// Sequencer for the SPI EEPROM master: frame state, shift registers and line
// levels, advanced by one item per enable. Depends on spiee_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spiee_seq
	import spiee_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     step,
	input  wire in_item_t item,
	input  wire opcodes_t opcodes,
	output out_item_t     result
);

	phase_t     phase_q, phase_d;
	logic [1:0] byte_q, byte_d;
	logic [2:0] bit_q, bit_d;
	logic       half_q, half_d;
	logic [7:0] tx_q, tx_d;
	logic [7:0] rx_q, rx_d;
	logic [8:0] addr_q, addr_d;
	logic [7:0] data_q, data_d;
	logic [2:0] settle_q, settle_d;
	logic       cs_q, cs_d;
	logic       mosi_q, mosi_d;
	logic       sck_q, sck_d;

	logic       is_req, is_tick, at_gap, rx_byte;
	logic [7:0] tx_sel, tx_src;
	logic [2:0] settle_inc;
	logic [1:0] byte_inc;

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			byte_q   <= '0;
			bit_q    <= '0;
			half_q   <= 1'b0;
			tx_q     <= '0;
			rx_q     <= '0;
			addr_q   <= '0;
			data_q   <= '0;
			settle_q <= '0;
			cs_q     <= 1'b1;
			mosi_q   <= 1'b0;
			sck_q    <= 1'b0;
		end else if (step) begin
			phase_q  <= phase_d;
			byte_q   <= byte_d;
			bit_q    <= bit_d;
			half_q   <= half_d;
			tx_q     <= tx_d;
			rx_q     <= rx_d;
			addr_q   <= addr_d;
			data_q   <= data_d;
			settle_q <= settle_d;
			cs_q     <= cs_d;
			mosi_q   <= mosi_d;
			sck_q    <= sck_d;
		end
	end

	assign is_req  = (item.kind == KIND_READ) || (item.kind == KIND_WRITE);
	assign is_tick = (item.kind == KIND_TICK) && (phase_q != PH_IDLE);
	assign at_gap  = (byte_q == BYTE_GAP);
	assign rx_byte = ((phase_q == PH_READ) && (byte_q == 2'd2)) ||
		((phase_q == PH_POLL) && (byte_q == 2'd1));
	assign settle_inc = settle_q + 3'd1;
	assign byte_inc   = byte_q + 2'd1;

	// Byte to transmit in the current slot
	always_comb begin
		unique case (phase_q)
			PH_READ: begin
				if (byte_q == 2'd0) begin
					tx_sel = addr_q[ADDR_HI_BIT] ? opcodes.read_hi : opcodes.read_lo;
				end else begin
					tx_sel = addr_q[7:0];
				end
			end
			PH_WREN: tx_sel = opcodes.wren;
			PH_WRITE: begin
				if (byte_q == 2'd0) begin
					tx_sel = addr_q[ADDR_HI_BIT] ? opcodes.write_hi : opcodes.write_lo;
				end else if (byte_q == 2'd1) begin
					tx_sel = addr_q[7:0];
				end else begin
					tx_sel = data_q;
				end
			end
			PH_POLL: tx_sel = opcodes.rdsr;
			default: tx_sel = opcodes.wrdi;
		endcase
	end

	// A new byte is loaded on its first bit
	assign tx_src = (bit_q == 3'd0) ? tx_sel : tx_q;

	// Next state
	always_comb begin
		phase_d  = phase_q;
		byte_d   = byte_q;
		bit_d    = bit_q;
		half_d   = half_q;
		tx_d     = tx_q;
		rx_d     = rx_q;
		addr_d   = addr_q;
		data_d   = data_q;
		settle_d = settle_q;
		cs_d     = cs_q;
		mosi_d   = mosi_q;
		sck_d    = sck_q;
		if (is_req) begin
			if (phase_q == PH_IDLE) begin
				addr_d  = item.address;
				data_d  = item.write_data;
				phase_d = (item.kind == KIND_WRITE) ? PH_WREN : PH_READ;
				byte_d  = '0;
				bit_d   = '0;
				half_d  = 1'b0;
			end
		end else if (is_tick) begin
			if (phase_q == PH_SETTLE) begin
				settle_d = settle_inc;
				if (settle_inc >= SETTLE_TICKS) begin
					phase_d = PH_POLL;
					byte_d  = '0;
					bit_d   = '0;
					half_d  = 1'b0;
				end
			end else if (at_gap) begin
				// release chip select, then pick the next frame
				cs_d   = 1'b1;
				sck_d  = 1'b0;
				byte_d = '0;
				bit_d  = '0;
				half_d = 1'b0;
				unique case (phase_q)
					PH_WREN: phase_d = PH_WRITE;
					PH_WRITE: begin
						settle_d = '0;
						phase_d  = (SETTLE_TICKS == 3'd0) ? PH_POLL : PH_SETTLE;
					end
					PH_POLL: phase_d = rx_q[STATUS_WIP_BIT] ? PH_POLL : PH_WRDI;
					default: phase_d = PH_IDLE;
				endcase
			end else if (!half_q) begin
				// low tick: select, drive or sample
				sck_d  = 1'b0;
				cs_d   = 1'b0;
				half_d = 1'b1;
				if (rx_byte) begin
					rx_d = {rx_q[6:0], item.miso};
				end else begin
					mosi_d = tx_src[7];
					tx_d   = {tx_src[6:0], 1'b0};
				end
			end else begin
				// high tick: raise SCK, count the bit
				sck_d  = 1'b1;
				half_d = 1'b0;
				bit_d  = bit_q + 3'd1;
				if (bit_q == 3'd7) begin
					byte_d = (byte_inc >= frame_bytes(phase_q)) ? BYTE_GAP : byte_inc;
				end
			end
		end
	end

	// Result for this item
	always_comb begin
		result.chip_select_n = cs_d;
		result.serial_clock  = sck_d;
		result.mosi          = mosi_d;
		result.busy_res      = (phase_d != PH_IDLE);
		result.done_res      = is_tick && at_gap &&
			((phase_q == PH_READ) || (phase_q == PH_WRDI));
		result.read_data     = (is_tick && at_gap && (phase_q == PH_READ)) ? rx_q : 8'h00;
		result.rejected      = is_req && (phase_q != PH_IDLE);
	end

endmodule

`default_nettype wire

FILE: src/spi_eeprom_byte_access_master.sv
// Top level of the SPI EEPROM byte access master: input stage, sequencer,
// opcode registers and result register. Depends on spiee_pkg, spiee_cfg, spiee_seq.
//
// Usage: items arrive on item/item_valid/item_ready, one per transfer. An item
// is a read request, a write request or a tick (one half SCK period). Each item
// yields exactly one result on result/result_valid/result_ready, carrying the
// chip select, SCK and MOSI levels after the item plus busy, done, read data and
// a reject flag for requests made while a sequence runs.
// Path: an accepted item is registered in the input stage and moves on to the
// result register when the stage advances; that load raises result_valid.
// Throughput: one item per clock while the result register drains; the
// sequencer takes one step per item in the cycle the item leaves the input
// stage.
// Stalls: while result_ready is low the result register holds, the input stage
// still takes one more item, and item_ready drops only when both are full.
// Reset: arst_n clears both stages, puts the sequencer idle with chip select
// high and SCK low, and loads the default opcodes. Opcode writes on cfg_write
// take effect at once and are meant for idle periods.
`timescale 1ns / 1ps
`default_nettype none

module spi_eeprom_byte_access_master
	import spiee_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 item_valid,
	output logic                      item_ready,
	input  wire in_item_t             item,
	output logic                      result_valid,
	input  wire logic                 result_ready,
	output out_item_t                 result,
	input  wire logic                 cfg_write,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]           cfg_data
);

	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t result_q;
	logic      result_valid_q;
	out_item_t step_result;
	opcodes_t  opcodes;
	logic      advance;

	// Handshake: the stage moves when the result register is free or draining
	assign advance    = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready = !valid_s1 || advance;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && item_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	spiee_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.opcodes   (opcodes)
	);

	spiee_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.item    (item_s1),
		.opcodes (opcodes),
		.result  (step_result)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= step_result;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

FILE: src/spiee_checker.sv
// Port-level checks for the SPI EEPROM master, bound to the top level.
// Depends on spiee_pkg and spi_eeprom_byte_access_master.
`timescale 1ns / 1ps
`default_nettype none

module spiee_checker
	import spiee_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      result_valid,
	input wire logic      result_ready,
	input wire out_item_t result
);

	// A stalled result transfer keeps its payload
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// A finished sequence leaves the bus released and the block idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.done_res |->
			result.chip_select_n && !result.serial_clock && !result.busy_res)
		else $error("done without bus release");

	// Rejects only happen while a sequence keeps running
	a_reject_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.rejected |-> result.busy_res && !result.done_res)
		else $error("reject while idle");

	// Read data shows only on a finishing result
	a_data_done: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.read_data != 8'h00) |-> result.done_res)
		else $error("read data outside done");

endmodule

bind spi_eeprom_byte_access_master spiee_checker u_spiee_checker (.*);

`default_nettype wire

FILE: bench/testbench.sv
// Self-checking bench for spi_eeprom_byte_access_master: drives read, write and tick items,
// predicts the SPI line levels of every item and checks each result in order.
// Depends on spiee_pkg and the RTL under src; needs no files or arguments.
`timescale 1ns / 1ps

module testbench;
	import spiee_pkg::*;

	// The fourth item kind has no meaning; the block must ignore it
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int STALL_LIMIT  = 2000;
	localparam int PHASE_ITEMS  = 50;
	localparam int POLL_BUDGET  = 120;
	localparam int REPORT_LIMIT = 10;

	typedef enum int {MISO_LOW, MISO_HIGH, MISO_RANDOM} miso_mode_t;

	// Line-level predictor plus the queue of levels still owed by the block
	class spi_level_scoreboard;
		logic [7:0] opcode [0:6];
		phase_t     phase;
		logic [1:0] byte_slot;
		logic [2:0] bit_slot;
		logic       high_half;
		logic [7:0] tx_shift;
		logic [7:0] rx_shift;
		logic [8:0] held_addr;
		logic [7:0] held_byte;
		logic [2:0] settle_count;
		logic       cs_n;
		logic       sck;
		logic       mosi;
		out_item_t  expected_levels [$];
		int         failures;
		int         results_seen;

		function new();
			opcode[REG_WREN]     = RST_WREN;
			opcode[REG_WRDI]     = RST_WRDI;
			opcode[REG_RDSR]     = RST_RDSR;
			opcode[REG_READ_LO]  = RST_READ_LO;
			opcode[REG_READ_HI]  = RST_READ_HI;
			opcode[REG_WRITE_LO] = RST_WRITE_LO;
			opcode[REG_WRITE_HI] = RST_WRITE_HI;
			phase        = PH_IDLE;
			byte_slot    = '0;
			bit_slot     = '0;
			high_half    = 1'b0;
			tx_shift     = '0;
			rx_shift     = '0;
			held_addr    = '0;
			held_byte    = '0;
			settle_count = '0;
			cs_n         = 1'b1;
			sck          = 1'b0;
			mosi         = 1'b0;
			failures     = 0;
			results_seen = 0;
		endfunction

		function void write_opcode(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
			opcode[idx] = value;
		endfunction

		function int pending();
			return expected_levels.size();
		endfunction

		function void start_frame(phase_t next);
			phase     = next;
			byte_slot = '0;
			bit_slot  = '0;
			high_half = 1'b0;
		endfunction

		// Advance the sequencer by one accepted item and queue the levels it leaves
		function void take_item(in_item_t it);
			out_item_t  lv;
			logic [1:0] nbytes;
			lv = '0;
			case (it.kind)
				KIND_READ, KIND_WRITE: begin
					if (phase != PH_IDLE) begin
						lv.rejected = 1'b1;
					end else begin
						held_addr = it.address;
						held_byte = it.write_data;
						start_frame(it.kind == KIND_WRITE ? PH_WREN : PH_READ);
					end
				end
				KIND_TICK: begin
					if (phase == PH_IDLE) begin
						// nothing running, levels stay
					end else if (phase == PH_SETTLE) begin
						settle_count = settle_count + 3'd1;
						if (settle_count >= SETTLE_TICKS)
							start_frame(PH_POLL);
					end else if (byte_slot == BYTE_GAP) begin
						// release tick: deselect, park SCK, pick the next frame
						cs_n = 1'b1;
						sck  = 1'b0;
						case (phase)
							PH_READ: begin
								phase          = PH_IDLE;
								lv.done_res    = 1'b1;
								lv.read_data   = rx_shift;
							end
							PH_WREN: start_frame(PH_WRITE);
							PH_WRITE: begin
								settle_count = '0;
								if (SETTLE_TICKS == 3'd0)
									start_frame(PH_POLL);
								else
									phase = PH_SETTLE;
							end
							PH_POLL: start_frame(rx_shift[STATUS_WIP_BIT] ? PH_POLL : PH_WRDI);
							default: begin
								phase       = PH_IDLE;
								lv.done_res = 1'b1;
							end
						endcase
						byte_slot = '0;
						bit_slot  = '0;
						high_half = 1'b0;
					end else if (!high_half) begin
						// low half: select, set MOSI or sample MISO
						sck  = 1'b0;
						cs_n = 1'b0;
						if ((phase == PH_READ && byte_slot == 2'd2) ||
						    (phase == PH_POLL && byte_slot == 2'd1)) begin
							rx_shift = {rx_shift[6:0], it.miso};
						end else begin
							if (bit_slot == 3'd0) begin
								case (phase)
									PH_READ: begin
										if (byte_slot == 2'd0)
											tx_shift = held_addr[ADDR_HI_BIT] ?
												opcode[REG_READ_HI] : opcode[REG_READ_LO];
										else
											tx_shift = held_addr[7:0];
									end
									PH_WREN: tx_shift = opcode[REG_WREN];
									PH_WRITE: begin
										if (byte_slot == 2'd0)
											tx_shift = held_addr[ADDR_HI_BIT] ?
												opcode[REG_WRITE_HI] : opcode[REG_WRITE_LO];
										else if (byte_slot == 2'd1)
											tx_shift = held_addr[7:0];
										else
											tx_shift = held_byte;
									end
									PH_POLL: tx_shift = opcode[REG_RDSR];
									default: tx_shift = opcode[REG_WRDI];
								endcase
							end
							mosi     = tx_shift[7];
							tx_shift = {tx_shift[6:0], 1'b0};
						end
						high_half = 1'b1;
					end else begin
						// high half: SCK rises, count the bit
						sck       = 1'b1;
						high_half = 1'b0;
						bit_slot  = bit_slot + 3'd1;
						if (bit_slot == 3'd0) begin
							byte_slot = byte_slot + 2'd1;
							if (phase == PH_READ || phase == PH_WRITE)
								nbytes = 2'd3;
							else if (phase == PH_POLL)
								nbytes = 2'd2;
							else
								nbytes = 2'd1;
							if (byte_slot >= nbytes)
								byte_slot = BYTE_GAP;
						end
					end
				end
				default: ;
			endcase
			lv.chip_select_n = cs_n;
			lv.serial_clock  = sck;
			lv.mosi          = mosi;
			lv.busy_res      = (phase != PH_IDLE);
			expected_levels.push_back(lv);
		endfunction

		function void report(string what, out_item_t want, out_item_t got);
			failures++;
			if (failures <= REPORT_LIMIT)
				$display("result %0d %s: want cs_n=%b sck=%b mosi=%b busy=%b done=%b rd=%h rej=%b, got cs_n=%b sck=%b mosi=%b busy=%b done=%b rd=%h rej=%b",
					results_seen, what,
					want.chip_select_n, want.serial_clock, want.mosi, want.busy_res,
					want.done_res, want.read_data, want.rejected,
					got.chip_select_n, got.serial_clock, got.mosi, got.busy_res,
					got.done_res, got.read_data, got.rejected);
		endfunction

		function void compare_levels(out_item_t got);
			out_item_t want;
			results_seen++;
			if (expected_levels.size() == 0) begin
				report("unexpected", '0, got);
				return;
			end
			want = expected_levels.pop_front();
			if (got.chip_select_n !== want.chip_select_n ||
			    got.serial_clock !== want.serial_clock ||
			    got.mosi !== want.mosi ||
			    got.busy_res !== want.busy_res ||
			    got.done_res !== want.done_res ||
			    got.read_data !== want.read_data ||
			    got.rejected !== want.rejected)
				report("mismatch", want, got);
		endfunction
	endclass

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 item_valid   = 1'b0;
	logic                 item_ready;
	in_item_t             item         = '0;
	logic                 result_valid;
	logic                 result_ready = 1'b0;
	out_item_t            result;
	logic                 cfg_write    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index    = '0;
	logic [7:0]           cfg_data     = '0;

	bit paced       = 1'b0;
	int stall_left  = 0;
	int idle_cycles = 0;
	int items_sent  = 0;

	spi_level_scoreboard sb = new();

	spi_eeprom_byte_access_master i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	// Gap lengths: mostly none, some short, a few long
	function automatic int pick_gap();
		int r;
		if (!paced)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic in_item_t random_item(logic [1:0] kind);
		in_item_t it;
		it.kind       = kind;
		it.address    = 9'($urandom_range(0, 511));
		it.write_data = 8'($urandom_range(0, 255));
		it.miso       = 1'($urandom_range(0, 1));
		return it;
	endfunction

	// Both transfers are observed on the rising edge
	always @(posedge clk) begin
		if (arst_n && item_valid && item_ready)
			sb.take_item(item);
		if (arst_n && result_valid && result_ready)
			sb.compare_levels(result);
	end

	// Receiver back-pressure
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left   <= stall_left - 1;
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
			stall_left   <= pick_gap();
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready) || cfg_write) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Called at a falling edge; returns at the falling edge after the transfer
	task automatic send_item(in_item_t it);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item       <= it;
		item_valid <= 1'b1;
		do begin
			@(posedge clk);
		end while (!item_ready);
		@(negedge clk);
		items_sent++;
	endtask

	// Hold the sender until every queued result has come back
	task automatic wait_results();
		item_valid <= 1'b0;
		do begin
			@(negedge clk);
		end while (sb.pending() != 0);
	endtask

	// Feed ticks until the running sequence ends, with optional stray items
	task automatic finish_access(miso_mode_t mode, int noise_pct);
		in_item_t it;
		int       ticks;
		ticks = 0;
		while (sb.phase != PH_IDLE) begin
			if ($urandom_range(0, 99) < noise_pct) begin
				case ($urandom_range(0, 2))
					0:       it = random_item(KIND_READ);
					1:       it = random_item(KIND_WRITE);
					default: it = random_item(KIND_UNUSED);
				endcase
			end else begin
				it = random_item(KIND_TICK);
				ticks++;
				// a stuck busy status would poll forever, so it clears eventually
				if (mode == MISO_LOW || ticks > POLL_BUDGET)
					it.miso = 1'b0;
				else if (mode == MISO_HIGH)
					it.miso = 1'b1;
			end
			send_item(it);
			if (paced && $urandom_range(0, 299) == 0)
				wait_results();
		end
	endtask

	initial begin
		in_item_t   it;
		logic [7:0] value;
		int         phase_start;

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		// Directed: idle items, rejects and stray kind mid-read, opcode variants,
		// repeated status polls
		send_item(random_item(KIND_TICK));
		send_item(random_item(KIND_UNUSED));
		it = random_item(KIND_READ);
		it.address = 9'h1ff;
		send_item(it);
		it = random_item(KIND_WRITE);
		it.address    = 9'h000;
		it.write_data = 8'h00;
		send_item(it);
		send_item(random_item(KIND_READ));
		send_item(random_item(KIND_UNUSED));
		finish_access(MISO_HIGH, 0);
		it = random_item(KIND_READ);
		it.address = 9'h000;
		send_item(it);
		finish_access(MISO_LOW, 0);
		it = random_item(KIND_WRITE);
		it.address    = 9'h100;
		it.write_data = 8'hff;
		send_item(it);
		finish_access(MISO_HIGH, 0);
		it = random_item(KIND_WRITE);
		it.address    = 9'h0ff;
		it.write_data = 8'h00;
		send_item(it);
		finish_access(MISO_LOW, 0);
		wait_results();

		// Random phases, each under its own opcode set
		for (int p = 0; p < 5; p++) begin
			for (int i = 0; i < 7; i++) begin
				if (p == 0)
					value = 8'hff;
				else if (p == 1)
					value = 8'h00;
				else
					value = 8'($urandom_range(0, 255));
				cfg_write <= 1'b1;
				cfg_index <= CFG_IDX_W'(i);
				cfg_data  <= value;
				sb.write_opcode(CFG_IDX_W'(i), value);
				@(negedge clk);
			end
			cfg_write <= 1'b0;
			paced = (p != 1);
			phase_start = items_sent;
			while (items_sent - phase_start < PHASE_ITEMS) begin
				if ($urandom_range(0, 4) == 0) begin
					send_item(random_item($urandom_range(0, 1) ? KIND_TICK : KIND_UNUSED));
				end else begin
					send_item(random_item($urandom_range(0, 99) < 60 ? KIND_READ : KIND_WRITE));
					finish_access(MISO_RANDOM, 4);
				end
			end
			wait_results();
		end

		repeat (4) @(posedge clk);
		if (sb.pending() != 0) begin
			$display("%0d results never arrived", sb.pending());
			sb.failures += sb.pending();
		end
		if (sb.failures == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
